// ===== hdl/cma_pkg.sv =====
// Shared types and constants for the covariance matrix accumulator.
package cma_pkg;
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_COV  = 2'd1;
   localparam logic [1:0] OP_MEAN = 2'd2;
   localparam logic [1:0] OP_CLR  = 2'd3;
   localparam int SUM_W   = 33;
   localparam int CROSS_W = 48;
   localparam int NUM_W   = 64;
   localparam int DEN_W   = 34;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 17;
endpackage

// ===== hdl/covariance_matrix_accumulator.sv =====
// Top level: row buffer, sum memories, commit sequencer and read path.
//
//  channel | direction | payload
//  req     | in        | tdata {col_feature, row_feature, sample}, tuser op
//  rsp     | out       | tdata {rows_seen, value}, tuser too_few_rows
//  csr     | in        | features_in_use
//
// A push is taken whenever the block is idle; the push that completes a row, while fewer
// than MAX_ROWS rows are held, then holds the input while the feature sums and cross sums are updated.
// A read holds the input after its transfer while the cross sum is read, the operands are
// formed and the divider runs; a result still waiting in the output register adds its wait.
// After reset, and after a clear, a pass zeroes every entry of the cross-sum memory one entry
// a cycle; no request is taken then.
module covariance_matrix_accumulator #(
   parameter int MAX_FEATURES = 16,
   parameter int MAX_ROWS     = 65536,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // sample[15:0], row_feature[19:16], col_feature[23:20]
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // value[31:0], rows_seen[48:32], zero[55:49]
   output logic        rsp_tuser,  // too_few_rows
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata   // features_in_use
);
   localparam int TRI = MAX_FEATURES * (MAX_FEATURES + 1) / 2;
   localparam int TW  = $clog2(TRI);
   localparam int FW  = $clog2(MAX_FEATURES);
   localparam int SW  = cma_pkg::SUM_W;
   localparam int CW  = cma_pkg::CROSS_W;
   localparam int NW  = cma_pkg::NUM_W;

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_PUSH = 4'd2, S_CA = 4'd3,
      S_CB = 4'd4, S_RD = 4'd5, S_RD2 = 4'd6, S_M1 = 4'd7, S_M2 = 4'd8,
      S_DIV = 4'd9, S_OUT = 4'd10, S_FS = 4'd11, S_HOLD = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [4:0]  fiu_ff;
   logic [FW-1:0] pos_ff, pos_in;
   logic [cma_pkg::CNT_W-1:0] n_ff, n_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [FW-1:0] a_ff, a_in, b_ff, b_in;
   logic [TW-1:0] t_ff, t_in;
   logic [1:0]  op_ff, op_in;
   logic        oor_ff, oor_in;
   logic [FW:0] fw;
   logic [SW-1:0] fsum [MAX_FEATURES];
   logic [SW-1:0] fsum_in [MAX_FEATURES];
   logic signed [15:0] samp;
   logic        acc;

   // row buffer memory
   logic rb_we; logic [FW-1:0] rb_wa, rb_ra; logic [15:0] rb_rd;
   // cross memory
   logic cx_we; logic [TW-1:0] cx_wa, cx_ra; logic [CW-1:0] cx_wd, cx_rd;
   logic signed [15:0] xa_ff, xa_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [NW-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic [cma_pkg::DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0] cxr_ff, cxr_in;
   logic        dv_start, dv_done;
   logic [31:0] dv_q;
   logic [31:0] val_ff, val_in;
   logic [cma_pkg::CNT_W-1:0] rows_ff, rows_in;
   logic        few_ff, few_in;
   logic        ov_ff, ov_in;

   cma_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_row (
      .clock, .wr_en(rb_we), .wr_addr(rb_wa), .wr_data(samp), .rd_addr(rb_ra),
      .rd_data(rb_rd));
   cma_ram #(.WIDTH(CW), .DEPTH(TRI)) u_cross (
      .clock, .wr_en(cx_we), .wr_addr(cx_wa), .wr_data(cx_wd), .rd_addr(cx_ra),
      .rd_data(cx_rd));
   cma_divider u_div (
      .clock, .reset, .start(dv_start), .num(m1_ff - m2_ff), .den(den_ff),
      .done(dv_done), .quot(dv_q));

   function automatic logic [TW-1:0] tri_idx(input logic [FW-1:0] a, input logic [FW-1:0] b);
      int ai;
      ai = int'(a);
      return TW'(ai * MAX_FEATURES - (ai * (ai - 1)) / 2 + (int'(b) - ai)) ;
   endfunction

   always_comb begin
      if (fiu_ff == 5'd0) fw = (FW+1)'(1);
      else if (int'(fiu_ff) > MAX_FEATURES) fw = (FW+1)'(MAX_FEATURES);
      else fw = (FW+1)'(fiu_ff);
      samp = 16'($signed(req_tdata[SAMPLE_BITS-1:0]));
   end

   assign req_tready = (st_ff == S_IDLE);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      st_in = st_ff; pos_in = pos_ff; n_in = n_ff; clr_in = clr_ff;
      a_in = a_ff; b_in = b_ff; t_in = t_ff; op_in = op_ff; oor_in = oor_ff;
      fsum_in = fsum; xa_in = xa_ff; prod_in = prod_ff;
      m1_in = m1_ff; m2_in = m2_ff; den_in = den_ff; cxr_in = cxr_ff;
      val_in = val_ff; rows_in = rows_ff; few_in = few_ff; ov_in = ov_ff; dv_start = 1'b0;
      rb_we = 1'b0; rb_wa = pos_ff; rb_ra = a_ff;
      cx_we = 1'b0; cx_wa = t_ff; cx_wd = cx_rd + CW'(prod_ff); cx_ra = t_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (st_ff)
         S_CLR: begin
            cx_we = 1'b1; cx_wa = clr_ff; cx_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (int'(clr_ff) == TRI - 1) st_in = S_IDLE;
         end
         S_IDLE: if (acc) begin
            op_in = req_tuser;
            a_in = req_tdata[16 +: FW]; b_in = req_tdata[20 +: FW];
            unique case (req_tuser)
               cma_pkg::OP_PUSH: begin
                  rb_we = 1'b1;
                  if ((FW+1)'(pos_ff) + 1'b1 >= fw) begin
                     pos_in = '0;
                     if (int'(n_ff) < MAX_ROWS) begin
                        a_in = '0; b_in = '0; t_in = '0; st_in = S_FS;
                     end
                  end else pos_in = pos_ff + 1'b1;
               end
               cma_pkg::OP_CLR: begin
                  for (int i = 0; i < MAX_FEATURES; i++) fsum_in[i] = '0;
                  n_in = '0; pos_in = '0; clr_in = '0; st_in = S_CLR;
               end
               default: begin
                  oor_in = (int'(req_tdata[19:16]) >= int'(fw)) ||
                     (req_tuser == cma_pkg::OP_COV && int'(req_tdata[23:20]) >= int'(fw));
                  if (req_tdata[16 +: FW] > req_tdata[20 +: FW] &&
                      req_tuser == cma_pkg::OP_COV) begin
                     a_in = req_tdata[20 +: FW]; b_in = req_tdata[16 +: FW];
                  end
                  st_in = S_RD;
               end
            endcase
         end
         S_FS: begin
            // feature sums from row buffer: read here, added in S_PUSH, one feature at a time
            rb_ra = a_ff;
            st_in = S_PUSH;
         end
         S_PUSH: begin
            fsum_in[a_ff] = fsum[a_ff] + SW'($signed(rb_rd));
            if ((FW+1)'(a_ff) + 1'b1 >= fw) begin
               a_in = '0; b_in = '0; rb_ra = '0; st_in = S_CA;
            end else begin
               a_in = a_ff + 1'b1; rb_ra = a_ff + 1'b1; st_in = S_FS;
            end
         end
         S_CA: begin
            rb_ra = a_ff; st_in = S_CB;
         end
         S_CB: begin
            // rb_rd holds x[a]; latch, then walk b with x[b] reads
            xa_in = $signed(rb_rd);
            b_in = a_ff; rb_ra = a_ff; t_in = tri_idx(a_ff, a_ff); cx_ra = tri_idx(a_ff, a_ff);
            st_in = S_M1;
         end
         S_M1: begin
            // rb_rd = x[b], cx_rd = cross[t]
            prod_in = xa_ff * $signed(rb_rd);
            st_in = S_M2;
         end
         S_M2: begin
            cx_we = 1'b1; cx_wa = t_ff; cx_wd = cx_rd + CW'(prod_ff);
            if ((FW+1)'(b_ff) + 1'b1 < fw) begin
               b_in = b_ff + 1'b1; t_in = t_ff + 1'b1;
               rb_ra = b_ff + 1'b1; cx_ra = t_ff + 1'b1; st_in = S_M1;
            end else if ((FW+1)'(a_ff) + 1'b1 < fw) begin
               a_in = a_ff + 1'b1; rb_ra = a_ff + 1'b1; st_in = S_CB;
            end else begin
               n_in = n_ff + 1'b1; st_in = S_IDLE;
            end
         end
         S_RD: begin
            cx_ra = tri_idx(a_ff, b_ff); st_in = S_RD2;
         end
         S_RD2: begin
            cxr_in = cx_rd;
            if (op_ff == cma_pkg::OP_COV) begin
               m1_in = NW'($signed(fsum[a_ff])) * NW'($signed(fsum[b_ff]));
               den_in = cma_pkg::DEN_W'(n_ff) * cma_pkg::DEN_W'(n_ff - 1'b1);
            end else begin
               m1_in = NW'($signed(fsum[a_ff]));
               den_in = cma_pkg::DEN_W'(n_ff);
            end
            st_in = (op_ff == cma_pkg::OP_COV) ? S_DIV : S_OUT;
            if (op_ff == cma_pkg::OP_MEAN) begin
               m2_in = '0; dv_start = 1'b0; st_in = S_DIV;
            end
         end
         S_DIV: begin
            // second product (covariance only), then divide
            if (op_ff == cma_pkg::OP_COV) begin
               m2_in = m1_ff;
               m1_in = NW'(n_ff) * NW'($signed(cxr_ff));
            end
            st_in = S_OUT;
            op_in = cma_pkg::OP_CLR;
         end
         S_OUT: begin
            if (op_ff == cma_pkg::OP_CLR) begin
               dv_start = 1'b1; op_in = cma_pkg::OP_PUSH;
            end else if (dv_done) begin
               st_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // quotient stays put; wait until the output register is free
            if (!ov_ff || rsp_tready) begin
               val_in = (n_ff < cma_pkg::CNT_W'(2) || oor_ff) ? 32'd0 : dv_q;
               rows_in = n_ff;
               few_in = (n_ff < cma_pkg::CNT_W'(2));
               ov_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; pos_ff <= '0; n_ff <= '0; ov_ff <= 1'b0;
         fiu_ff <= 5'd16;
         for (int i = 0; i < MAX_FEATURES; i++) fsum[i] <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; pos_ff <= pos_in; n_ff <= n_in; ov_ff <= ov_in;
         if (csr_we) fiu_ff <= csr_wdata;
         fsum <= fsum_in;
      end
      a_ff <= a_in; b_ff <= b_in; t_ff <= t_in; op_ff <= op_in; oor_ff <= oor_in;
      xa_ff <= xa_in; prod_ff <= prod_in;
      m1_ff <= m1_in; m2_ff <= m2_in; den_ff <= den_in; cxr_ff <= cxr_in; val_ff <= val_in;
      rows_ff <= rows_in; few_ff <= few_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {7'd0, rows_ff, val_ff};
   assign rsp_tuser = few_ff;
endmodule

// ===== hdl/cma_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module cma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/cma_divider.sv =====
// Restoring divider: signed numerator over positive denominator, truncated, saturated to 32 bits.
module cma_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cma_pkg::NUM_W-1:0]  num,
   input  logic [cma_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [cma_pkg::VAL_W-1:0]  quot
);
   localparam int NW = cma_pkg::NUM_W;
   localparam int DW = cma_pkg::DEN_W;
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [DW+1:0] trial;
   logic [NW-1:0] mag;

   always_comb begin
      mag = num[NW-1] ? (~num + 1'b1) : num;
      trial = {r_ff, q_ff[NW-1]} - {2'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      if (start) begin
         q_in = mag; r_in = '0; d_in = den; neg_in = num[NW-1];
         busy_in = 1'b1; cnt_in = '0;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            r_in = trial[DW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(NW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (q_ff > 64'h8000_0000) quot = 32'h8000_0000;
         else quot = 32'(~q_ff + 1'b1);
      end else begin
         if (q_ff > 64'h7FFF_FFFF) quot = 32'h7FFF_FFFF;
         else quot = q_ff[31:0];
      end
   end
   assign done = done_ff;
endmodule

// ===== verif/covariance_matrix_accumulator_test.sv =====
// Testbench for the covariance matrix accumulator: queued stimulus, scoreboard, watchdog.
`timescale 1ns / 100ps

module covariance_matrix_accumulator_test;

   localparam int NFEAT      = 16;
   localparam int ROW_LIMIT  = 65536;
   localparam int SETTLE     = 400;
   localparam int STALL_LEN  = 400;
   localparam int WDOG_LIMIT = 6000;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] sample;
      logic [3:0]         fa;
      logic [3:0]         fb;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               few;
      logic [16:0]        rows;
   } stat_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [4:0]  csr_wdata;

   covariance_matrix_accumulator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // predictor state
   longint      sum_x [NFEAT];
   longint      sum_xy [NFEAT][NFEAT];
   longint      row_buf [NFEAT];
   int          row_pos;
   int          rows_held;
   logic [4:0]  width_reg;

   req_item_type    pending_reqs[$];
   stat_result_type expected_stats[$];
   req_item_type    in_flight;
   int  send_idle_pct, recv_idle_pct;
   int  stall_token;
   int  stall_seen = 0;
   int  stall_left = 0;
   int  errors = 0;
   int  reads_checked = 0;
   int  pushes_sent = 0;
   int  clears_sent = 0;
   int  rows_done = 0;
   int  quiet_cycles = 0;

   function automatic int row_width();
      if (width_reg < 5'd1) return 1;
      if (width_reg > 5'd16) return NFEAT;
      return int'(width_reg);
   endfunction

   function automatic logic signed [31:0] clamp32(longint q);
      if (q > 64'sd2147483647) return 32'sh7fffffff;
      if (q < -64'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

   task automatic zero_store();
      for (int a = 0; a < NFEAT; a++) begin
         sum_x[a] = 0;
         row_buf[a] = 0;
         for (int b = 0; b < NFEAT; b++) sum_xy[a][b] = 0;
      end
      row_pos = 0;
      rows_held = 0;
   endtask

   task automatic predict_stats(req_item_type it);
      int f, lo, hi;
      longint n, num, den;
      stat_result_type r;
      f = row_width();
      n = rows_held;
      case (it.op)
         cma_pkg::OP_PUSH: begin
            row_buf[row_pos] = it.sample;
            if (row_pos + 1 >= f) begin
               if (rows_held < ROW_LIMIT) begin
                  for (int a = 0; a < f; a++) begin
                     sum_x[a] += row_buf[a];
                     for (int b = a; b < f; b++) sum_xy[a][b] += row_buf[a] * row_buf[b];
                  end
                  rows_held++;
                  rows_done++;
               end
               row_pos = 0;
            end else begin
               row_pos++;
            end
         end
         cma_pkg::OP_CLR: zero_store();
         default: begin
            r.value = 0;
            if (n >= 2) begin
               if (it.op == cma_pkg::OP_COV) begin
                  if (it.fa < f && it.fb < f) begin
                     lo = (it.fa < it.fb) ? it.fa : it.fb;
                     hi = (it.fa < it.fb) ? it.fb : it.fa;
                     num = n * sum_xy[lo][hi] - sum_x[lo] * sum_x[hi];
                     den = n * (n - 1);
                     r.value = clamp32(num / den);
                  end
               end else if (it.fa < f) begin
                  r.value = clamp32(sum_x[it.fa] / n);
               end
            end
            r.few = (n < 2);
            r.rows = n[16:0];
            expected_stats.insert(expected_stats.size(), r);
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= cma_pkg::OP_PUSH;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_stats(in_flight);
            if (in_flight.op == cma_pkg::OP_PUSH) pushes_sent++;
            if (in_flight.op == cma_pkg::OP_CLR) clears_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {in_flight.fb, in_flight.fa, in_flight.sample};
               req_tuser <= in_flight.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      stat_result_type got, want;
      if (rsp_tvalid && rsp_tready && !reset) begin
         got.value = rsp_tdata[31:0];
         got.few = rsp_tuser;
         got.rows = rsp_tdata[48:32];
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result value=%0d few=%0b rows=%0d",
                     $time, got.value, got.few, got.rows);
            errors++;
         end else begin
            want = expected_stats.pop_front();
            reads_checked++;
            if (got.value !== want.value) begin
               $display("%0t: value mismatch expected %0d actual %0d",
                        $time, want.value, got.value);
               errors++;
            end
            if (got.few !== want.few) begin
               $display("%0t: too_few_rows mismatch expected %0b actual %0b",
                        $time, want.few, got.few);
               errors++;
            end
            if (got.rows !== want.rows) begin
               $display("%0t: rows_seen mismatch expected %0d actual %0d",
                        $time, want.rows, got.rows);
               errors++;
            end
         end
      end
      if (stall_token != stall_seen) begin
         stall_seen = stall_token;
         stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  expected_stats.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_req(logic [1:0] op, logic [15:0] s, logic [3:0] fa, logic [3:0] fb);
      req_item_type it;
      it.op = op;
      it.sample = s;
      it.fa = fa;
      it.fb = fb;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(logic [4:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg = v;
   endtask

   // mostly whole rows of random content, with reads, noise and rare clears
   task automatic random_phase(int count);
      int k, pick, f;
      logic [15:0] s;
      f = row_width();
      k = 0;
      while (k < count) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            for (int j = 0; j < f && k < count; j++) begin
               case ($urandom_range(7))
                  0: s = 16'h8000;
                  1: s = 16'h7fff;
                  2: s = 16'($urandom_range(15)) - 16'd8;
                  default: s = 16'($urandom);
               endcase
               queue_req(cma_pkg::OP_PUSH, s, 4'($urandom), 4'($urandom));
               k++;
            end
         end else if (pick < 86) begin
            queue_req(cma_pkg::OP_COV, 16'($urandom), 4'($urandom_range(f > 15 ? 15 : f)),
                      4'($urandom));
            k++;
         end else if (pick < 97) begin
            queue_req(cma_pkg::OP_MEAN, 16'($urandom), 4'($urandom), 4'($urandom));
            k++;
         end else if (pick < 99) begin
            queue_req(cma_pkg::OP_PUSH, 16'($urandom), 4'($urandom), 4'($urandom));
            k++;
         end else begin
            queue_req(cma_pkg::OP_CLR, 16'($urandom), 4'($urandom), 4'($urandom));
            k++;
         end
      end
   endtask

   initial begin
      logic [4:0] widths [8];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 26;
      recv_idle_pct = 26;
      stall_token = 0;
      width_reg = 5'd16;
      zero_store();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reads with no rows, a full row of extremes, a second row, reads
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_MEAN, 16'h0, 4'd15, 4'd3);
      for (int j = 0; j < NFEAT; j++)
         queue_req(cma_pkg::OP_PUSH, (j % 2) ? 16'h8000 : 16'h7fff, 4'hf, 4'hf);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd1, 4'd2);
      for (int j = 0; j < NFEAT; j++)
         queue_req(cma_pkg::OP_PUSH, (j % 2) ? 16'h7fff : 16'hffff, 4'h0, 4'h0);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd15, 4'd0);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd0, 4'd15);
      queue_req(cma_pkg::OP_MEAN, 16'hffff, 4'd1, 4'd9);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd15, 4'd15);
      drain();

      // narrow rows, reads past the width, then a clear with a read after it
      write_width(5'd2);
      queue_req(cma_pkg::OP_PUSH, 16'h8000, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_PUSH, 16'h8000, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_PUSH, 16'h7fff, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_PUSH, 16'h8000, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd1, 4'd0);
      queue_req(cma_pkg::OP_COV, 16'h0, 4'd1, 4'd9);
      queue_req(cma_pkg::OP_MEAN, 16'h0, 4'd5, 4'd0);
      queue_req(cma_pkg::OP_CLR, 16'h0, 4'd0, 4'd0);
      queue_req(cma_pkg::OP_MEAN, 16'h0, 4'd0, 4'd0);
      drain();

      widths = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd5, 5'd8, 5'd2};
      for (int ph = 0; ph < 8; ph++) begin
         write_width(ph < 7 ? widths[ph] : 5'($urandom_range(1, 20)));
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = 26;
            recv_idle_pct = 26;
         end
         if (ph == 5) begin
            @(posedge clock);
            stall_token++;
         end
         random_phase(row_width() > 8 ? 140 : 240);
         // leave some rows half built so the next width change lands mid-row
         drain();
      end

      $display("covered %0d pushes, %0d complete rows, %0d clears, %0d reads checked",
               pushes_sent, rows_done, clears_sent, reads_checked);
      $display("row widths from 0 up to 31 programmed, including a long receiver stall");
      if (errors == 0 && expected_stats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d results outstanding", errors, expected_stats.size());
         $display("tb: failure");
      end
      $finish;
   end
endmodule
